FILE: hdl/rts_pkg.sv
// Package for the repeater transmit sequencer: widths, mode codes,
// configuration register indexes and stream word layouts.
// No dependencies.
package rts_pkg;

  localparam int TIME_BITS = 32;
  localparam int WIN_BITS  = 24;
  localparam int IVAL_BITS = 16;
  localparam int MS_PER_S  = 1000;
  localparam int IVAL_MS_BITS = IVAL_BITS + 10;

  localparam int MODE_BITS = 4;
  localparam logic [MODE_BITS-1:0] MODE_INIT     = 4'd0;
  localparam logic [MODE_BITS-1:0] MODE_IDLE     = 4'd1;
  localparam logic [MODE_BITS-1:0] MODE_PREID    = 4'd2;
  localparam logic [MODE_BITS-1:0] MODE_ID       = 4'd3;
  localparam logic [MODE_BITS-1:0] MODE_POSTID   = 4'd4;
  localparam logic [MODE_BITS-1:0] MODE_ACTIVE   = 4'd5;
  localparam logic [MODE_BITS-1:0] MODE_PRECOURT = 4'd6;
  localparam logic [MODE_BITS-1:0] MODE_COURT    = 4'd7;
  localparam logic [MODE_BITS-1:0] MODE_HANG     = 4'd8;
  localparam logic [MODE_BITS-1:0] MODE_LOCKOUT  = 4'd9;
  localparam logic [MODE_BITS-1:0] MODE_MUTED    = 4'd10;

  localparam logic [1:0] MUTE_NONE   = 2'd0;
  localparam logic [1:0] MUTE_PARK   = 2'd1;
  localparam logic [1:0] MUTE_UNMUTE = 2'd2;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRE_ID    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_POST_ID   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRE_COURT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HANG      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_QUIET     = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_ID_IVAL   = 3'd7;

  localparam int IN_BITS  = 16;
  localparam int OUT_BITS = 16;

  // Input word; the last member listed sits at bit 0
  typedef struct packed {
    logic [6:0] pad;
    logic [1:0] mute_cmd;
    logic [3:0] courtesy_select;
    logic       courtesy_tone_done;
    logic       id_tone_done;
    logic       audio_active;
  } in_word_t;

  // Result word; the last member listed sits at bit 0
  typedef struct packed {
    logic [2:0]           pad;
    logic                 lockout_extended;
    logic                 reset_audio_delay;
    logic [3:0]           courtesy_kind;
    logic                 start_courtesy_tone;
    logic                 start_id_tone;
    logic                 ptt;
    logic [MODE_BITS-1:0] mode_code;
  } out_word_t;

endpackage

FILE: hdl/repeater_tx_sequencer.sv
// Repeater transmit sequencer top level: mode state machine, timers,
// configuration registers and a two-entry result buffer.
// Depends on rts_pkg.
//
// Usage: each word on the in_ stream is one millisecond tick carrying the
// receiver audio flag, the tone-done flags, the courtesy tone select and a
// mute command. For every accepted tick exactly one result word leaves on
// the out_ stream: the mode after the tick, PTT, the tone start pulses,
// the latched courtesy kind, the audio-delay reset and lockout extension.
// Each result is registered in the main register, or in the skid register
// while out stalls. Throughput: one tick per cycle while in_tready is high;
// the tick update is one register stage (increment, deadline add/compare, decode).
// The output side has a main register and a skid register, so in_tready
// stays high while one result waits; it drops only when both hold words,
// and no result is lost or repeated however long the receiver stalls.
// cfg_ writes (always ready) load the window registers; they are meant to
// happen while no tick is in flight.
// Reset (synchronous, rst_n low) returns the mode to init, clears all
// timers and flags, and loads the default window values.
module repeater_tx_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] audio_active, [1] id_tone_done, [2] courtesy_tone_done,
  // [6:3] courtesy_select, [8:7] mute_cmd, [15:9] zero
  input  logic [rts_pkg::IN_BITS-1:0]        in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] mode_code, [4] ptt, [5] start_id_tone, [6] start_courtesy_tone,
  // [10:7] courtesy_kind, [11] reset_audio_delay, [12] lockout_extended,
  // [15:13] zero
  output logic [rts_pkg::OUT_BITS-1:0]       out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rts_pkg::*;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [WIN_BITS-1:0]  win_t;

  // configuration
  win_t                    timeout_r, lockout_r, pre_id_r, post_id_r;
  win_t                    pre_court_r, hang_r, quiet_r;
  logic [IVAL_MS_BITS-1:0] ival_ms_r;

  // sequencer state
  logic [MODE_BITS-1:0] mode_r, mode_nxt;
  time_t                now_r, now_nxt;
  time_t                state_end_r, state_end_nxt;
  logic                 state_end_vld_r, state_end_vld_nxt;
  time_t                tot_end_r, tot_end_nxt;
  logic                 tot_vld_r, tot_vld_nxt;
  time_t                last_comm_r, last_comm_nxt;
  time_t                last_id_r, last_id_nxt;
  logic                 id_sent_r, id_sent_nxt;
  time_t                idle_start_r, idle_start_nxt;
  logic                 ptt_r, ptt_nxt;
  logic [3:0]           court_latch_r, court_latch_nxt;

  // output buffer
  out_word_t out_r, skid_r, res;
  logic      out_valid_r, skid_valid_r;

  in_word_t  iw;
  logic      in_fire, out_fire;
  logic      p_id, p_court, p_rst, p_ext;
  logic      timed_out, id_due, go_active;
  logic      set_win;
  win_t      win;

  assign iw        = in_word_t'(in_tdata);
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  assign now_nxt   = now_r + time_t'(1);
  assign timed_out = state_end_vld_r && (now_nxt > state_end_r);
  assign id_due    = (ival_ms_r != '0) && (last_comm_r > last_id_r) &&
                     (!id_sent_r || (now_nxt > last_id_r + time_t'(ival_ms_r))) &&
                     (now_nxt > idle_start_r + time_t'(quiet_r));

  always_comb begin
    mode_nxt        = mode_r;
    ptt_nxt         = ptt_r;
    last_comm_nxt   = last_comm_r;
    last_id_nxt     = last_id_r;
    id_sent_nxt     = id_sent_r;
    idle_start_nxt  = idle_start_r;
    court_latch_nxt = court_latch_r;
    tot_vld_nxt     = tot_vld_r;
    tot_end_nxt     = tot_end_r;
    p_id            = 1'b0;
    p_court         = 1'b0;
    p_rst           = 1'b0;
    p_ext           = 1'b0;
    go_active       = 1'b0;
    set_win         = 1'b0;
    win             = '0;
    if (iw.mute_cmd == MUTE_PARK || iw.mute_cmd == MUTE_UNMUTE) begin
      mode_nxt       = (iw.mute_cmd == MUTE_PARK) ? MODE_MUTED : MODE_IDLE;
      idle_start_nxt = now_nxt;
      ptt_nxt        = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_INIT: begin
          mode_nxt       = MODE_IDLE;
          idle_start_nxt = now_nxt;
          ptt_nxt        = 1'b0;
        end
        MODE_IDLE: begin
          if (id_due) begin
            ptt_nxt  = 1'b1;
            mode_nxt = MODE_PREID;
            set_win  = 1'b1;
            win      = pre_id_r;
          end else if (iw.audio_active) begin
            go_active = 1'b1;
          end
        end
        MODE_PREID: begin
          if (timed_out) begin
            last_id_nxt = now_nxt;
            id_sent_nxt = 1'b1;
            ptt_nxt     = 1'b1;
            p_id        = 1'b1;
            mode_nxt    = MODE_ID;
            set_win     = 1'b1;
          end
        end
        MODE_ID: begin
          if (iw.id_tone_done) begin
            ptt_nxt  = 1'b1;
            mode_nxt = MODE_POSTID;
            set_win  = 1'b1;
            win      = post_id_r;
          end
        end
        MODE_POSTID: begin
          if (timed_out) begin
            mode_nxt       = MODE_IDLE;
            idle_start_nxt = now_nxt;
            ptt_nxt        = 1'b0;
          end
        end
        MODE_ACTIVE: begin
          last_comm_nxt = now_nxt;
          if (tot_vld_r && (now_nxt > tot_end_r)) begin
            ptt_nxt  = 1'b0;
            mode_nxt = MODE_LOCKOUT;
            set_win  = 1'b1;
            win      = lockout_r;
          end else if (!iw.audio_active) begin
            court_latch_nxt = iw.courtesy_select;
            mode_nxt        = MODE_PRECOURT;
            set_win         = 1'b1;
            win             = pre_court_r;
          end
        end
        MODE_PRECOURT: begin
          if (timed_out) begin
            p_court  = 1'b1;
            mode_nxt = MODE_COURT;
            set_win  = 1'b1;
          end else if (iw.audio_active) begin
            go_active = 1'b1;
          end
        end
        MODE_COURT: begin
          if (iw.courtesy_tone_done) begin
            mode_nxt = MODE_HANG;
            set_win  = 1'b1;
            win      = hang_r;
          end
        end
        MODE_HANG: begin
          if (timed_out) begin
            mode_nxt       = MODE_IDLE;
            idle_start_nxt = now_nxt;
            ptt_nxt        = 1'b0;
          end else if (iw.audio_active) begin
            go_active = 1'b1;
          end
        end
        MODE_LOCKOUT: begin
          if (timed_out) begin
            set_win = 1'b1;
            if (iw.audio_active) begin
              ptt_nxt  = 1'b0;
              p_ext    = 1'b1;
              mode_nxt = MODE_LOCKOUT;
              win      = lockout_r;
            end else begin
              ptt_nxt  = 1'b1;
              mode_nxt = MODE_PREID;
              win      = pre_id_r;
            end
          end
        end
        default: ;
      endcase
      if (go_active) begin
        mode_nxt    = MODE_ACTIVE;
        set_win     = 1'b1;
        win         = '0;
        tot_vld_nxt = (timeout_r != '0);
        tot_end_nxt = (timeout_r != '0) ? now_nxt + time_t'(timeout_r) : '0;
        p_rst       = 1'b1;
        ptt_nxt     = 1'b1;
      end
    end
    if (set_win) begin
      state_end_vld_nxt = (win != '0);
      state_end_nxt     = (win != '0) ? now_nxt + time_t'(win) : '0;
    end else begin
      state_end_vld_nxt = state_end_vld_r;
      state_end_nxt     = state_end_r;
    end
  end

  always_comb begin
    res                     = '0;
    res.mode_code           = mode_nxt;
    res.ptt                 = ptt_nxt;
    res.start_id_tone       = p_id;
    res.start_courtesy_tone = p_court;
    res.courtesy_kind       = court_latch_nxt;
    res.reset_audio_delay   = p_rst;
    res.lockout_extended    = p_ext;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= win_t'(0);
      lockout_r   <= win_t'(60000);
      pre_id_r    <= win_t'(500);
      post_id_r   <= win_t'(500);
      pre_court_r <= win_t'(500);
      hang_r      <= win_t'(2000);
      quiet_r     <= win_t'(5000);
      ival_ms_r   <= IVAL_MS_BITS'(600 * MS_PER_S);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMEOUT:   timeout_r   <= cfg_data;
        REG_LOCKOUT:   lockout_r   <= cfg_data;
        REG_PRE_ID:    pre_id_r    <= cfg_data;
        REG_POST_ID:   post_id_r   <= cfg_data;
        REG_PRE_COURT: pre_court_r <= cfg_data;
        REG_HANG:      hang_r      <= cfg_data;
        REG_QUIET:     quiet_r     <= cfg_data;
        REG_ID_IVAL:   ival_ms_r   <= IVAL_MS_BITS'(cfg_data[IVAL_BITS-1:0]) *
                                      IVAL_MS_BITS'(MS_PER_S);
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_INIT;
      now_r           <= '0;
      state_end_r     <= '0;
      state_end_vld_r <= 1'b0;
      tot_end_r       <= '0;
      tot_vld_r       <= 1'b0;
      last_comm_r     <= '0;
      last_id_r       <= '0;
      id_sent_r       <= 1'b0;
      idle_start_r    <= '0;
      ptt_r           <= 1'b0;
      court_latch_r   <= '0;
    end else if (in_fire) begin
      mode_r          <= mode_nxt;
      now_r           <= now_nxt;
      state_end_r     <= state_end_nxt;
      state_end_vld_r <= state_end_vld_nxt;
      tot_end_r       <= tot_end_nxt;
      tot_vld_r       <= tot_vld_nxt;
      last_comm_r     <= last_comm_nxt;
      last_id_r       <= last_id_nxt;
      id_sent_r       <= id_sent_nxt;
      idle_start_r    <= idle_start_nxt;
      ptt_r           <= ptt_nxt;
      court_latch_r   <= court_latch_nxt;
    end
  end

  // result buffer: main register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (out_fire && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while the output register is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed or vanished");

  a_ptt_off_modes: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_INIT || mode_r == MODE_IDLE || mode_r == MODE_MUTED ||
     mode_r == MODE_LOCKOUT) |-> !ptt_r)
    else $error("PTT keyed in a mode that must leave it off");

  a_id_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.start_id_tone) |-> (out_r.mode_code == MODE_ID))
    else $error("ID tone start outside ID mode");

  a_active_pulse_ptt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.reset_audio_delay) |->
      (out_r.ptt && out_r.mode_code == MODE_ACTIVE))
    else $error("audio delay reset without entering active with PTT");

endmodule

FILE: verif/tb.sv
// Testbench for repeater_tx_sequencer: directed table, then randomized tick
// streams over several window settings, checked against an in-bench predictor.
// Depends on rts_pkg and the repeater_tx_sequencer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rts_pkg::*;

  localparam logic [1:0] MUTE_UNUSED = 2'd3;
  localparam int DIR_N = 25;
  localparam int N_PHASES = 6;
  localparam int PHASE_TICKS = 85;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic                 typed;
    logic [MODE_BITS-1:0] mode;
    logic                 ptt;
    logic [3:0]           kind;
    logic                 rst_delay;
    logic                 audio;
    logic                 id_done;
    logic                 court_done;
    logic [3:0]           csel;
    logic [1:0]           mute;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  in_word_t                 in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_BITS-1:0]      out_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predictor state
  logic [MODE_BITS-1:0] m_mode;
  logic [TIME_BITS-1:0] t_now, t_end, t_tot, t_comm, t_id, t_idle;
  logic                 end_ok, tot_ok, id_sent, ptt_q;
  logic [3:0]           kind_q;
  logic [23:0]          cfg_reg [8];
  logic [23:0]          cfg_set [8];

  out_word_t tx_status_q [$];
  int        n_fail = 0;
  int        rx_seen = 0;
  int        rx_seen_last = 0;
  int        rx_hold = 0;
  logic      rx_burst = 1'b0;
  logic      tx_burst = 1'b0;
  int        stall_cnt = 0;

  dir_row_t dir_tab [DIR_N] = '{
    '{1, MODE_IDLE,     0, 0,  0, 0, 0, 0, 0,  MUTE_NONE},
    '{1, MODE_MUTED,    0, 0,  0, 0, 0, 0, 0,  MUTE_PARK},
    '{1, MODE_MUTED,    0, 0,  0, 1, 0, 0, 0,  MUTE_UNUSED},
    '{1, MODE_IDLE,     0, 0,  0, 1, 0, 0, 0,  MUTE_UNMUTE},
    '{1, MODE_ACTIVE,   1, 0,  1, 1, 0, 0, 0,  MUTE_NONE},
    '{1, MODE_PRECOURT, 1, 15, 0, 0, 0, 0, 15, MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 1, 1, 15, MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 0, 0, 0,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 0, 1, 3,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 0, 5,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 0, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 1, 0, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 1, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 0, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 0, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 0, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 0, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 1, 0, 0, 9,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 0, 0, 6,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 0, 0, 6,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 1, 0, 6,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 0, 0, 6,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 1, 0, 6,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 0, 0, 6,  MUTE_NONE},
    '{0, MODE_INIT,     0, 0,  0, 0, 0, 0, 6,  MUTE_NONE}
  };

  repeater_tx_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void arm(input logic [MODE_BITS-1:0] m, input logic [23:0] win);
    m_mode = m;
    end_ok = (win != 0);
    t_end  = end_ok ? t_now + win : '0;
  endfunction

  function automatic void enter_idle();
    m_mode = MODE_IDLE;
    t_idle = t_now;
    ptt_q  = 1'b0;
  endfunction

  function automatic logic expired();
    return end_ok && (t_now > t_end);
  endfunction

  function automatic logic id_due();
    logic [TIME_BITS-1:0] id_next;
    logic [TIME_BITS-1:0] quiet_end;
    id_next   = t_id + cfg_reg[REG_ID_IVAL][IVAL_BITS-1:0] * 32'd1000;
    quiet_end = t_idle + cfg_reg[REG_QUIET];
    if (cfg_reg[REG_ID_IVAL][IVAL_BITS-1:0] == 0) return 1'b0;
    if (!(t_comm > t_id)) return 1'b0;
    if (id_sent && !(t_now > id_next)) return 1'b0;
    return t_now > quiet_end;
  endfunction

  task automatic clear_model();
    cfg_reg[REG_TIMEOUT]   = 24'd0;
    cfg_reg[REG_LOCKOUT]   = 24'd60000;
    cfg_reg[REG_PRE_ID]    = 24'd500;
    cfg_reg[REG_POST_ID]   = 24'd500;
    cfg_reg[REG_PRE_COURT] = 24'd500;
    cfg_reg[REG_HANG]      = 24'd2000;
    cfg_reg[REG_QUIET]     = 24'd5000;
    cfg_reg[REG_ID_IVAL]   = 24'd600;
    m_mode = MODE_INIT;
    {t_now, t_end, t_tot, t_comm, t_id, t_idle} = '0;
    {end_ok, tot_ok, id_sent, ptt_q} = '0;
    kind_q = '0;
  endtask

  task automatic predict_tx_status(input in_word_t w, output out_word_t r);
    logic go_active, p_id, p_court, p_rst, p_ext;
    {go_active, p_id, p_court, p_rst, p_ext} = '0;
    t_now = t_now + 1;
    if (w.mute_cmd == MUTE_PARK) begin
      enter_idle();
      m_mode = MODE_MUTED;
    end else if (w.mute_cmd == MUTE_UNMUTE) begin
      enter_idle();
    end else begin
      case (m_mode)
        MODE_INIT: enter_idle();
        MODE_IDLE: begin
          if (id_due()) begin
            ptt_q = 1'b1;
            arm(MODE_PREID, cfg_reg[REG_PRE_ID]);
          end else if (w.audio_active) begin
            go_active = 1'b1;
          end
        end
        MODE_PREID: begin
          if (expired()) begin
            t_id = t_now;
            id_sent = 1'b1;
            ptt_q = 1'b1;
            p_id = 1'b1;
            arm(MODE_ID, '0);
          end
        end
        MODE_ID: begin
          if (w.id_tone_done) begin
            ptt_q = 1'b1;
            arm(MODE_POSTID, cfg_reg[REG_POST_ID]);
          end
        end
        MODE_POSTID: if (expired()) enter_idle();
        MODE_ACTIVE: begin
          t_comm = t_now;
          if (tot_ok && t_now > t_tot) begin
            ptt_q = 1'b0;
            arm(MODE_LOCKOUT, cfg_reg[REG_LOCKOUT]);
          end else if (!w.audio_active) begin
            kind_q = w.courtesy_select;
            arm(MODE_PRECOURT, cfg_reg[REG_PRE_COURT]);
          end
        end
        MODE_PRECOURT: begin
          if (expired()) begin
            p_court = 1'b1;
            arm(MODE_COURT, '0);
          end else if (w.audio_active) begin
            go_active = 1'b1;
          end
        end
        MODE_COURT: if (w.courtesy_tone_done) arm(MODE_HANG, cfg_reg[REG_HANG]);
        MODE_HANG: begin
          if (expired()) enter_idle();
          else if (w.audio_active) go_active = 1'b1;
        end
        MODE_LOCKOUT: begin
          if (expired()) begin
            if (w.audio_active) begin
              ptt_q = 1'b0;
              p_ext = 1'b1;
              arm(MODE_LOCKOUT, cfg_reg[REG_LOCKOUT]);
            end else begin
              ptt_q = 1'b1;
              arm(MODE_PREID, cfg_reg[REG_PRE_ID]);
            end
          end
        end
        default: ;
      endcase
      if (go_active) begin
        arm(MODE_ACTIVE, '0);
        tot_ok = (cfg_reg[REG_TIMEOUT] != 0);
        t_tot  = tot_ok ? t_now + cfg_reg[REG_TIMEOUT] : '0;
        p_rst  = 1'b1;
        ptt_q  = 1'b1;
      end
    end
    r = '0;
    r.mode_code           = m_mode;
    r.ptt                 = ptt_q;
    r.start_id_tone       = p_id;
    r.start_courtesy_tone = p_court;
    r.courtesy_kind       = kind_q;
    r.reset_audio_delay   = p_rst;
    r.lockout_extended    = p_ext;
  endtask

  task automatic send_tick(input in_word_t w, input logic typed, input out_word_t want);
    int gap;
    out_word_t p;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tx_status(w, p);
    tx_status_q.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [23:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_reg[idx] = (idx == REG_ID_IVAL) ? {8'd0, data[IVAL_BITS-1:0]} : data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_and_load();
    in_tvalid = 1'b0;
    while (tx_status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    for (int i = 0; i < 8; i++) write_reg(i[CFG_IDX_BITS-1:0], cfg_set[i]);
  endtask

  task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_word_t'(out_tdata);
      rx_seen++;
      if (tx_status_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected word, expected none got %h", $time, out_tdata);
      end else begin
        want = tx_status_q.pop_front();
        flag_field("mode_code", want.mode_code, got.mode_code);
        flag_field("ptt", want.ptt, got.ptt);
        flag_field("start_id_tone", want.start_id_tone, got.start_id_tone);
        flag_field("start_courtesy_tone", want.start_courtesy_tone, got.start_courtesy_tone);
        flag_field("courtesy_kind", want.courtesy_kind, got.courtesy_kind);
        flag_field("reset_audio_delay", want.reset_audio_delay, got.reset_audio_delay);
        flag_field("lockout_extended", want.lockout_extended, got.lockout_extended);
      end
    end
  end

  always @(negedge clk) begin
    if (rx_seen != rx_seen_last) begin
      rx_seen_last = rx_seen;
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      rx_hold = rx_burst ? 0 : $urandom_range(0, 14);
    end
    if (rx_hold > 0) begin
      out_tready = 1'b0;
      rx_hold--;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    in_word_t  w;
    out_word_t want;
    logic      aud;
    int        r;
    clear_model();
    aud = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    cfg_set = '{24'd4, 24'd2, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1};
    drain_and_load();
    for (int i = 0; i < DIR_N; i++) begin
      w = '0;
      w.audio_active       = dir_tab[i].audio;
      w.id_tone_done       = dir_tab[i].id_done;
      w.courtesy_tone_done = dir_tab[i].court_done;
      w.courtesy_select    = dir_tab[i].csel;
      w.mute_cmd           = dir_tab[i].mute;
      want = '0;
      want.mode_code         = dir_tab[i].mode;
      want.ptt               = dir_tab[i].ptt;
      want.courtesy_kind     = dir_tab[i].kind;
      want.reset_audio_delay = dir_tab[i].rst_delay;
      send_tick(w, dir_tab[i].typed, want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        4: cfg_set = '{default: 24'd0};
        5: cfg_set = '{default: 24'hFFFFFF};
        default: begin
          cfg_set[REG_TIMEOUT]   = 24'($urandom_range(0, 16));
          cfg_set[REG_LOCKOUT]   = 24'($urandom_range(0, 6));
          cfg_set[REG_PRE_ID]    = 24'($urandom_range(0, 4));
          cfg_set[REG_POST_ID]   = 24'($urandom_range(0, 4));
          cfg_set[REG_PRE_COURT] = 24'($urandom_range(0, 4));
          cfg_set[REG_HANG]      = 24'($urandom_range(0, 6));
          cfg_set[REG_QUIET]     = 24'($urandom_range(0, 8));
          cfg_set[REG_ID_IVAL]   = 24'($urandom_range(0, 2));
        end
      endcase
      drain_and_load();
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if ($urandom_range(0, 4) == 0) aud = !aud;
        w = '0;
        w.audio_active       = aud;
        w.id_tone_done       = ($urandom_range(0, 2) == 0);
        w.courtesy_tone_done = ($urandom_range(0, 2) == 0);
        w.courtesy_select    = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 93) w.mute_cmd = MUTE_NONE;
        else if (r < 96) w.mute_cmd = MUTE_UNMUTE;
        else if (r < 98) w.mute_cmd = MUTE_PARK;
        else w.mute_cmd = MUTE_UNUSED;
        send_tick(w, 1'b0, '0);
      end
    end

    in_tvalid = 1'b0;
    while (tx_status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
